>>> sv/kftl_pkg.sv
// shared codes, widths and controller/datapath interface types for the keyframe track lookup
`timescale 1ns / 1ps
package kftl_pkg;

    localparam int TIME_W  = 32;
    localparam int VAL_W   = 32;
    localparam int TOL_W   = 16;
    localparam int FRAC_W  = 17;
    localparam int KCNT_W  = 7;
    localparam int DIV_STEPS = 16;

    localparam logic [1:0] CMD_WRITE  = 2'd0;
    localparam logic [1:0] CMD_SAMPLE = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;
    localparam logic [1:0] CMD_IGNORE = 2'd3;

    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    localparam logic [1:0] KIND_OK     = 2'd0;
    localparam logic [1:0] KIND_FULL   = 2'd1;
    localparam logic [1:0] KIND_EMPTY  = 2'd2;
    localparam logic [1:0] KIND_SAMPLE = 2'd3;

    localparam logic [2:0] RA_IDX   = 3'd0;
    localparam logic [2:0] RA_IDXM1 = 3'd1;
    localparam logic [2:0] RA_FOUND = 3'd2;
    localparam logic [2:0] RA_SEED  = 3'd3;
    localparam logic [2:0] RA_PREV  = 3'd4;
    localparam logic [2:0] RA_NEXT  = 3'd5;

    localparam logic [1:0] WA_IDX   = 2'd0;
    localparam logic [1:0] WA_FOUND = 2'd1;
    localparam logic [1:0] WA_INS   = 2'd2;

    localparam logic [1:0] WD_SHIFT = 2'd0;
    localparam logic [1:0] WD_MOD   = 2'd1;
    localparam logic [1:0] WD_NEW   = 2'd2;

    typedef struct packed {
        logic       latch_in;
        logic       scan_init;
        logic       scan_eval;
        logic       rd_en;
        logic       wr_en;
        logic       clear_cnt;
        logic       inc_cnt;
        logic       seed_zero;
        logic       seed_load;
        logic       prev_load;
        logic       next_load;
        logic       div_init;
        logic       div_step;
        logic       res_load;
        logic [2:0] ra_sel;
        logic [1:0] wa_sel;
        logic [1:0] wd_sel;
        logic [1:0] res_kind;
    } ctl_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       count_zero;
        logic       full;
        logic       found;
        logic       seed_valid;
        logic       scan_stop;
        logic       last;
        logic       idx_gt_ins;
        logic       frac_ok;
        logic       out_free;
    } stat_t;

endpackage

>>> sv/kftl_datapath.sv
// key table memory, scan and bracket registers, serial divider and result register
`timescale 1ns / 1ps
module kftl_datapath #(
    parameter int MAX_KEYS = 64,
    parameter int AW = $clog2(MAX_KEYS),
    parameter int CW = $clog2(MAX_KEYS + 1)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  kftl_pkg::ctl_t                      ctl,
    output kftl_pkg::stat_t                     stat,
    input  logic [CW-1:0]                       idx,
    output logic [CW-1:0]                       count,
    input  logic [1:0]                          in_cmd,
    input  logic [kftl_pkg::TIME_W-1:0]         in_time,
    input  logic [1:0]                          in_comp,
    input  logic [kftl_pkg::VAL_W-1:0]          in_val,
    input  logic                                cfg_valid,
    input  logic [kftl_pkg::TOL_W-1:0]          cfg_data,
    input  logic                                m_ready,
    output logic                                m_valid,
    output logic [1:0]                          res_status,
    output logic [kftl_pkg::VAL_W-1:0]          res_prev_x,
    output logic [kftl_pkg::VAL_W-1:0]          res_prev_y,
    output logic [kftl_pkg::VAL_W-1:0]          res_prev_z,
    output logic [kftl_pkg::VAL_W-1:0]          res_next_x,
    output logic [kftl_pkg::VAL_W-1:0]          res_next_y,
    output logic [kftl_pkg::VAL_W-1:0]          res_next_z,
    output logic [kftl_pkg::FRAC_W-1:0]         res_fraction,
    output logic                                res_fraction_valid,
    output logic [kftl_pkg::KCNT_W-1:0]         res_key_count
);

    localparam int DIVQ_W = kftl_pkg::DIV_STEPS;

    typedef struct packed {
        logic [kftl_pkg::VAL_W-1:0]  z;
        logic [kftl_pkg::VAL_W-1:0]  y;
        logic [kftl_pkg::VAL_W-1:0]  x;
        logic [kftl_pkg::TIME_W-1:0] t;
    } entry_t;

    entry_t mem [MAX_KEYS];
    entry_t rd_data_reg;

    logic [1:0]                  cmd_reg;
    logic [kftl_pkg::TIME_W-1:0] t_reg;
    logic [1:0]                  comp_reg;
    logic [kftl_pkg::VAL_W-1:0]  val_reg;
    logic [kftl_pkg::TOL_W-1:0]  tol_reg;
    logic [CW-1:0]               count_reg;

    logic                        found_reg;
    logic [AW-1:0]               found_idx_reg;
    logic                        seed_hit_reg;
    logic                        seed_valid_reg;
    logic [AW-1:0]               seed_idx_reg;
    logic [CW-1:0]               ins_pos_reg;
    logic [AW-1:0]               prev_idx_reg;
    logic [AW-1:0]               next_idx_reg;
    logic [kftl_pkg::TIME_W-1:0] prev_time_reg;
    logic [kftl_pkg::TIME_W-1:0] len_reg;
    logic                        frac_ok_reg;

    logic [kftl_pkg::VAL_W-1:0]  seed_x_reg, seed_y_reg, seed_z_reg;
    logic [kftl_pkg::VAL_W-1:0]  prev_x_reg, prev_y_reg, prev_z_reg;
    logic [kftl_pkg::VAL_W-1:0]  next_x_reg, next_y_reg, next_z_reg;

    logic [kftl_pkg::TIME_W:0]   rem_reg;
    logic [DIVQ_W-1:0]           q_reg;

    logic                        m_valid_reg;

    logic [CW-1:0]               idxm1;
    logic [CW-1:0]               rd_sel_idx;
    logic [CW-1:0]               wr_sel_idx;
    logic [CW-1:0]               ins_ext;
    entry_t                      wr_data;
    entry_t                      new_entry;
    logic [kftl_pkg::TIME_W-1:0] e_t;
    logic [kftl_pkg::TIME_W-1:0] time_gap;
    logic                        in_tol;
    logic                        e_le, e_ge, e_lt;
    logic [kftl_pkg::TIME_W-1:0] pt_cur, pt_new;
    logic [kftl_pkg::TIME_W-1:0] len_now;
    logic [kftl_pkg::TIME_W:0]   r2;
    logic [CW+kftl_pkg::KCNT_W-1:0] count_ext;
    logic                        out_free;

    function automatic entry_t apply_comp(entry_t e, logic [1:0] c,
                                          logic [kftl_pkg::VAL_W-1:0] v);
        entry_t r;
        r = e;
        case (c)
            kftl_pkg::COMP_X: r.x = v;
            kftl_pkg::COMP_Y: r.y = v;
            kftl_pkg::COMP_Z: r.z = v;
            default:          r = e;
        endcase
        return r;
    endfunction

    assign idxm1    = idx - CW'(1);
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        case (ctl.ra_sel)
            kftl_pkg::RA_IDXM1: rd_sel_idx = idxm1;
            kftl_pkg::RA_FOUND: rd_sel_idx = CW'(found_idx_reg);
            kftl_pkg::RA_SEED:  rd_sel_idx = CW'(seed_idx_reg);
            kftl_pkg::RA_PREV:  rd_sel_idx = CW'(prev_idx_reg);
            kftl_pkg::RA_NEXT:  rd_sel_idx = CW'(next_idx_reg);
            default:            rd_sel_idx = idx;
        endcase
    end

    assign ins_ext = ins_pos_reg;

    always_comb begin
        case (ctl.wa_sel)
            kftl_pkg::WA_FOUND: wr_sel_idx = CW'(found_idx_reg);
            kftl_pkg::WA_INS:   wr_sel_idx = ins_ext;
            default:            wr_sel_idx = idx;
        endcase
    end

    always_comb begin
        new_entry.t = t_reg;
        new_entry.x = seed_x_reg;
        new_entry.y = seed_y_reg;
        new_entry.z = seed_z_reg;
        case (ctl.wd_sel)
            kftl_pkg::WD_MOD: wr_data = apply_comp(rd_data_reg, comp_reg, val_reg);
            kftl_pkg::WD_NEW: wr_data = apply_comp(new_entry, comp_reg, val_reg);
            default:          wr_data = rd_data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[wr_sel_idx[AW-1:0]] <= wr_data;
        end
        if (ctl.rd_en) begin
            rd_data_reg <= mem[rd_sel_idx[AW-1:0]];
        end
    end

    // scan compares on the word just read
    assign e_t      = rd_data_reg.t;
    assign time_gap = (e_t >= t_reg) ? (e_t - t_reg) : (t_reg - e_t);
    assign in_tol   = time_gap <= {{(kftl_pkg::TIME_W - kftl_pkg::TOL_W){1'b0}}, tol_reg};
    assign e_le   = e_t <= t_reg;
    assign e_ge   = e_t >= t_reg;
    assign e_lt   = e_t < t_reg;
    assign pt_cur = (idx == '0) ? e_t : prev_time_reg;
    assign pt_new = e_le ? e_t : pt_cur;
    assign len_now = e_t - pt_new;
    assign r2     = {rem_reg[kftl_pkg::TIME_W-1:0], 1'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= kftl_pkg::TOL_W'(655);
        end else if (cfg_valid) begin
            tol_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (ctl.clear_cnt) begin
            count_reg <= '0;
        end else if (ctl.inc_cnt) begin
            count_reg <= count_reg + CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.latch_in) begin
            cmd_reg  <= in_cmd;
            t_reg    <= in_time;
            comp_reg <= in_comp;
            val_reg  <= in_val;
        end
        if (ctl.scan_init) begin
            found_reg      <= 1'b0;
            found_idx_reg  <= '0;
            seed_hit_reg   <= 1'b0;
            seed_valid_reg <= 1'b0;
            seed_idx_reg   <= '0;
            ins_pos_reg    <= '0;
            prev_idx_reg   <= '0;
            next_idx_reg   <= '0;
            prev_time_reg  <= '0;
            len_reg        <= '0;
            frac_ok_reg    <= 1'b0;
        end else if (ctl.scan_eval) begin
            if (cmd_reg == kftl_pkg::CMD_WRITE) begin
                if (e_t == t_reg) begin
                    found_reg     <= 1'b1;
                    found_idx_reg <= idx[AW-1:0];
                end
                if (!seed_hit_reg && in_tol) begin
                    seed_hit_reg   <= 1'b1;
                    seed_valid_reg <= 1'b1;
                    seed_idx_reg   <= idx[AW-1:0];
                end else if (!seed_hit_reg && e_lt) begin
                    seed_valid_reg <= 1'b1;
                    seed_idx_reg   <= idx[AW-1:0];
                end
                if (e_lt) begin
                    ins_pos_reg <= idx + CW'(1);
                end
            end else begin
                prev_time_reg <= pt_new;
                if (e_le) begin
                    prev_idx_reg <= idx[AW-1:0];
                end
                if (e_ge) begin
                    next_idx_reg <= idx[AW-1:0];
                    len_reg      <= len_now;
                    frac_ok_reg  <= len_now != '0;
                end
            end
        end
        if (ctl.seed_zero) begin
            seed_x_reg <= '0;
            seed_y_reg <= '0;
            seed_z_reg <= '0;
        end else if (ctl.seed_load) begin
            seed_x_reg <= rd_data_reg.x;
            seed_y_reg <= rd_data_reg.y;
            seed_z_reg <= rd_data_reg.z;
        end
        if (ctl.prev_load) begin
            prev_x_reg <= rd_data_reg.x;
            prev_y_reg <= rd_data_reg.y;
            prev_z_reg <= rd_data_reg.z;
        end
        if (ctl.next_load) begin
            next_x_reg <= rd_data_reg.x;
            next_y_reg <= rd_data_reg.y;
            next_z_reg <= rd_data_reg.z;
        end
        // restoring division, one quotient bit a cycle
        if (ctl.div_init) begin
            rem_reg <= {1'b0, t_reg - prev_time_reg};
            q_reg   <= '0;
        end else if (ctl.div_step) begin
            if (r2 >= {1'b0, len_reg}) begin
                rem_reg <= r2 - {1'b0, len_reg};
                q_reg   <= {q_reg[DIVQ_W-2:0], 1'b1};
            end else begin
                rem_reg <= r2;
                q_reg   <= {q_reg[DIVQ_W-2:0], 1'b0};
            end
        end
    end

    assign count_ext = {{kftl_pkg::KCNT_W{1'b0}}, count_reg};

    always_ff @(posedge aclk) begin
        if (ctl.res_load) begin
            res_key_count      <= count_ext[kftl_pkg::KCNT_W-1:0];
            res_prev_x         <= '0;
            res_prev_y         <= '0;
            res_prev_z         <= '0;
            res_next_x         <= '0;
            res_next_y         <= '0;
            res_next_z         <= '0;
            res_fraction       <= '0;
            res_fraction_valid <= 1'b0;
            case (ctl.res_kind)
                kftl_pkg::KIND_FULL:  res_status <= kftl_pkg::STATUS_FULL;
                kftl_pkg::KIND_EMPTY: res_status <= kftl_pkg::STATUS_EMPTY;
                kftl_pkg::KIND_SAMPLE: begin
                    res_status         <= kftl_pkg::STATUS_OK;
                    res_prev_x         <= prev_x_reg;
                    res_prev_y         <= prev_y_reg;
                    res_prev_z         <= prev_z_reg;
                    res_next_x         <= next_x_reg;
                    res_next_y         <= next_y_reg;
                    res_next_z         <= next_z_reg;
                    res_fraction       <= frac_ok_reg ? {1'b0, q_reg} : '0;
                    res_fraction_valid <= frac_ok_reg;
                end
                default: res_status <= kftl_pkg::STATUS_OK;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.res_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign count   = count_reg;

    always_comb begin
        stat.cmd        = cmd_reg;
        stat.count_zero = count_reg == '0;
        stat.full       = count_reg >= CW'(MAX_KEYS);
        stat.found      = found_reg;
        stat.seed_valid = seed_valid_reg;
        stat.scan_stop  = e_ge;
        stat.last       = idx == (count_reg - CW'(1));
        stat.idx_gt_ins = idx > ins_pos_reg;
        stat.frac_ok    = frac_ok_reg;
        stat.out_free   = out_free;
    end

endmodule

>>> sv/kftl_ctrl.sv
// sequencing state machine for scan, insert shift, sample read-out and divide
`timescale 1ns / 1ps
module kftl_ctrl #(
    parameter int MAX_KEYS = 64,
    parameter int CW = $clog2(MAX_KEYS + 1)
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  kftl_pkg::stat_t stat,
    input  logic [CW-1:0]   count,
    output logic [CW-1:0]   idx,
    output kftl_pkg::ctl_t  ctl
);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_DISP     = 5'd1;
    localparam logic [4:0] S_SCAN_RD  = 5'd2;
    localparam logic [4:0] S_SCAN_EV  = 5'd3;
    localparam logic [4:0] S_WR_DEC   = 5'd4;
    localparam logic [4:0] S_WR_MOD   = 5'd5;
    localparam logic [4:0] S_WR_SEED  = 5'd6;
    localparam logic [4:0] S_SH_RD    = 5'd7;
    localparam logic [4:0] S_SH_WR    = 5'd8;
    localparam logic [4:0] S_WR_NEW   = 5'd9;
    localparam logic [4:0] S_SMP_RDP  = 5'd10;
    localparam logic [4:0] S_SMP_LATP = 5'd11;
    localparam logic [4:0] S_SMP_LATN = 5'd12;
    localparam logic [4:0] S_DIV      = 5'd13;
    localparam logic [4:0] S_FIN      = 5'd14;

    localparam int SW = $clog2(kftl_pkg::DIV_STEPS);

    logic [4:0]    state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [SW-1:0] step_reg, step_next;
    logic [1:0]    kind_reg, kind_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            step_reg  <= '0;
            kind_reg  <= kftl_pkg::KIND_OK;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
            kind_reg  <= kind_next;
        end
    end

    assign in_ready = state_reg == S_IDLE;
    assign idx      = idx_reg;

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        step_next  = step_reg;
        kind_next  = kind_reg;
        ctl        = '0;
        ctl.ra_sel = kftl_pkg::RA_IDX;
        ctl.wa_sel = kftl_pkg::WA_IDX;
        ctl.wd_sel = kftl_pkg::WD_SHIFT;
        ctl.res_kind = kind_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    ctl.latch_in = 1'b1;
                    state_next   = S_DISP;
                end
            end
            S_DISP: begin
                ctl.scan_init = 1'b1;
                idx_next      = '0;
                kind_next     = kftl_pkg::KIND_OK;
                case (stat.cmd)
                    kftl_pkg::CMD_WRITE: begin
                        state_next = stat.count_zero ? S_WR_DEC : S_SCAN_RD;
                    end
                    kftl_pkg::CMD_SAMPLE: begin
                        if (stat.count_zero) begin
                            kind_next  = kftl_pkg::KIND_EMPTY;
                            state_next = S_FIN;
                        end else begin
                            state_next = S_SCAN_RD;
                        end
                    end
                    kftl_pkg::CMD_CLEAR: begin
                        ctl.clear_cnt = 1'b1;
                        state_next    = S_FIN;
                    end
                    default: state_next = S_FIN;
                endcase
            end
            S_SCAN_RD: begin
                ctl.rd_en  = 1'b1;
                state_next = S_SCAN_EV;
            end
            S_SCAN_EV: begin
                ctl.scan_eval = 1'b1;
                if (stat.cmd == kftl_pkg::CMD_SAMPLE && stat.scan_stop) begin
                    state_next = S_SMP_RDP;
                end else if (stat.last) begin
                    state_next = (stat.cmd == kftl_pkg::CMD_WRITE) ? S_WR_DEC : S_SMP_RDP;
                end else begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_SCAN_RD;
                end
            end
            S_WR_DEC: begin
                if (stat.found) begin
                    ctl.rd_en  = 1'b1;
                    ctl.ra_sel = kftl_pkg::RA_FOUND;
                    state_next = S_WR_MOD;
                end else if (stat.full) begin
                    kind_next  = kftl_pkg::KIND_FULL;
                    state_next = S_FIN;
                end else if (stat.seed_valid) begin
                    ctl.rd_en  = 1'b1;
                    ctl.ra_sel = kftl_pkg::RA_SEED;
                    state_next = S_WR_SEED;
                end else begin
                    ctl.seed_zero = 1'b1;
                    idx_next      = count;
                    state_next    = S_SH_RD;
                end
            end
            S_WR_MOD: begin
                ctl.wr_en  = 1'b1;
                ctl.wa_sel = kftl_pkg::WA_FOUND;
                ctl.wd_sel = kftl_pkg::WD_MOD;
                state_next = S_FIN;
            end
            S_WR_SEED: begin
                ctl.seed_load = 1'b1;
                idx_next      = count;
                state_next    = S_SH_RD;
            end
            S_SH_RD: begin
                if (stat.idx_gt_ins) begin
                    ctl.rd_en  = 1'b1;
                    ctl.ra_sel = kftl_pkg::RA_IDXM1;
                    state_next = S_SH_WR;
                end else begin
                    state_next = S_WR_NEW;
                end
            end
            S_SH_WR: begin
                ctl.wr_en  = 1'b1;
                ctl.wa_sel = kftl_pkg::WA_IDX;
                ctl.wd_sel = kftl_pkg::WD_SHIFT;
                idx_next   = idx_reg - CW'(1);
                state_next = S_SH_RD;
            end
            S_WR_NEW: begin
                ctl.wr_en   = 1'b1;
                ctl.wa_sel  = kftl_pkg::WA_INS;
                ctl.wd_sel  = kftl_pkg::WD_NEW;
                ctl.inc_cnt = 1'b1;
                state_next  = S_FIN;
            end
            S_SMP_RDP: begin
                ctl.rd_en  = 1'b1;
                ctl.ra_sel = kftl_pkg::RA_PREV;
                state_next = S_SMP_LATP;
            end
            S_SMP_LATP: begin
                ctl.prev_load = 1'b1;
                ctl.rd_en     = 1'b1;
                ctl.ra_sel    = kftl_pkg::RA_NEXT;
                state_next    = S_SMP_LATN;
            end
            S_SMP_LATN: begin
                ctl.next_load = 1'b1;
                ctl.div_init  = 1'b1;
                kind_next     = kftl_pkg::KIND_SAMPLE;
                step_next     = '0;
                state_next    = stat.frac_ok ? S_DIV : S_FIN;
            end
            S_DIV: begin
                ctl.div_step = 1'b1;
                step_next    = step_reg + SW'(1);
                if (step_reg == SW'(kftl_pkg::DIV_STEPS - 1)) begin
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (stat.out_free) begin
                    ctl.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

>>> sv/keyframe_track_lookup_core.sv
// top level: stream ports, configuration write channel, controller and datapath
// one word at a time: no new word is taken until the current one has its result; a write
// scans the stored keys, then modifies the matching key or shifts later keys up and inserts;
// a sample scans for the bracketing keys, reads both and runs the divider when the fraction is valid
// the next word is taken once the current result sits in the output register
// aresetn (synchronous, active low) empties the table and sets match_tolerance to 655
`timescale 1ns / 1ps
module keyframe_track_lookup_core #(
    parameter int MAX_KEYS = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,   // key_time[31:0], component[33:32], comp_value[65:34]
    input  logic [1:0]   s_tuser,   // cmd[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    // prev_x, prev_y, prev_z, next_x, next_y, next_z, fraction[208:192], key_count[215:209]
    output logic [215:0] m_tdata,
    output logic [2:0]   m_tuser,   // status[1:0], fraction_valid[2]
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [15:0]  cfg_data   // match_tolerance
);

    localparam int AW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);

    kftl_pkg::ctl_t  ctl;
    kftl_pkg::stat_t stat;
    logic [CW-1:0]   idx;
    logic [CW-1:0]   count;
    logic            in_ready;

    logic [1:0]  res_status;
    logic [31:0] res_prev_x, res_prev_y, res_prev_z;
    logic [31:0] res_next_x, res_next_y, res_next_z;
    logic [16:0] res_fraction;
    logic        res_fraction_valid;
    logic [6:0]  res_key_count;

    assign s_tready  = in_ready;
    assign cfg_ready = 1'b1;

    kftl_ctrl #(
        .MAX_KEYS (MAX_KEYS),
        .CW       (CW)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (in_ready),
        .stat     (stat),
        .count    (count),
        .idx      (idx),
        .ctl      (ctl)
    );

    kftl_datapath #(
        .MAX_KEYS (MAX_KEYS),
        .AW       (AW),
        .CW       (CW)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .ctl                (ctl),
        .stat               (stat),
        .idx                (idx),
        .count              (count),
        .in_cmd             (s_tuser),
        .in_time            (s_tdata[31:0]),
        .in_comp            (s_tdata[33:32]),
        .in_val             (s_tdata[65:34]),
        .cfg_valid          (cfg_valid),
        .cfg_data           (cfg_data),
        .m_ready            (m_tready),
        .m_valid            (m_tvalid),
        .res_status         (res_status),
        .res_prev_x         (res_prev_x),
        .res_prev_y         (res_prev_y),
        .res_prev_z         (res_prev_z),
        .res_next_x         (res_next_x),
        .res_next_y         (res_next_y),
        .res_next_z         (res_next_z),
        .res_fraction       (res_fraction),
        .res_fraction_valid (res_fraction_valid),
        .res_key_count      (res_key_count)
    );

    assign m_tdata = {res_key_count, res_fraction, res_next_z, res_next_y, res_next_x,
                      res_prev_z, res_prev_y, res_prev_x};
    assign m_tuser = {res_fraction_valid, res_status};

endmodule
